@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands used by the checker file pfr_checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/pfr_pkg.sv @@
// ----------------------------------------------------------------------------
// pfr_pkg
// shared constants and types of the page frame replacer
// ----------------------------------------------------------------------------
package pfr_pkg;

    localparam int FRAMES_DEF    = 64;
    localparam int PAGE_BITS_DEF = 12;
    localparam int ADDR_W        = 32;
    localparam int PID_W         = 3;

    localparam int APB_AW = 2;
    localparam int APB_DW = 32;

    // register indexes
    localparam int REG_POLICY = 0;

    // policy codes
    localparam logic POL_FIFO = 1'b0;
    localparam logic POL_LRU  = 1'b1;

    // compare unit flags
    typedef struct packed {
        logic tag_eq;
        logic rank_zero;
        logic rank_above;
    } t_cmp_res;

endpackage

@@ rtl/page_frame_fifo_lru_replacer.sv @@
// ----------------------------------------------------------------------------
// page_frame_fifo_lru_replacer
// fully associative page frame table with fifo or lru replacement
// ----------------------------------------------------------------------------
// input channel (i_valid/o_ready) carries one access per beat: process id and
// virtual address. output channel (o_valid/i_ready) returns one beat per
// access: hit flag, frame index and replaced flag.
// the block takes one access at a time. a scan reads every frame's tag and
// rank through one compare unit, one frame per cycle, then a decide cycle
// picks the frame and, on a miss, writes the tag. under lru a second pass over
// the rank memory ages the ranks, again one frame per cycle.
// o_ready returns in the cycle after the result is taken. the result stays in
// its output register while i_ready is low, and no new access is taken until
// it leaves.
// reset empties the table, sets each rank to its frame index through per-frame
// valid bits, clears fifo pointer and fill count and selects fifo policy. no
// clearing pass is needed; the block is ready right after reset.
// policy sits at apb byte address 0; the user writes it only while idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module page_frame_fifo_lru_replacer #(
    parameter int FRAMES    = pfr_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = pfr_pkg::PAGE_BITS_DEF,
    localparam int FW       = $clog2(FRAMES)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // apb configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pfr_pkg::APB_AW-1:0]  paddr,
    input  logic [pfr_pkg::APB_DW-1:0]  pwdata,
    output logic [pfr_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    // access channel
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [pfr_pkg::PID_W-1:0]   i_process_id,
    input  logic [pfr_pkg::ADDR_W-1:0]  i_virtual_address,
    // result channel
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_hit,
    output logic [FW-1:0]               o_frame_index,
    output logic                        o_replaced
);

    localparam int CW = FW + 1;
    localparam int PW = pfr_pkg::ADDR_W - PAGE_BITS;
    localparam int TW = pfr_pkg::PID_W + PW;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_UPD,
        S_RESP
    } t_state;

    t_state      r_state;
    logic        r_policy;
    logic [TW-1:0] r_tag;
    logic [CW-1:0] r_cnt;
    logic        r_pv;
    logic [FW-1:0] r_pk;
    logic        r_pvld;
    logic        r_found;
    logic [FW-1:0] r_hit_idx;
    logic [FW-1:0] r_hit_rank;
    logic [FW-1:0] r_lru_idx;
    logic [FW-1:0] r_fill_rank;
    logic [FW-1:0] r_f;
    logic [FW-1:0] r_ref;
    logic [CW-1:0] r_fill;
    logic [FW-1:0] r_fifo;
    logic [FRAMES-1:0] r_rank_vld;
    logic        r_o_valid;
    logic        r_o_hit;
    logic [FW-1:0] r_o_frame;
    logic        r_o_repl;

    logic          issue;
    logic [FW-1:0] rd_addr;
    logic [TW-1:0] tag_q;
    logic [FW-1:0] rank_q;
    logic [FW-1:0] rank_eff;
    logic          tag_we;
    logic          rank_we;
    logic [FW-1:0] rank_wdata;
    logic [FW-1:0] rank_dec;
    logic          is_self;
    logic          apb_wr;
    pfr_pkg::t_cmp_res cmp;

    // decide cycle outcome
    logic          n_hit;
    logic          n_repl;
    logic [FW-1:0] n_f;
    logic [FW-1:0] n_ref;

    assign apb_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = {{(pfr_pkg::APB_DW-1){1'b0}}, r_policy};

    assign issue   = ((r_state == S_SCAN) || (r_state == S_UPD)) && (r_cnt < CW'(FRAMES));
    assign rd_addr = r_cnt[FW-1:0];

    // an entry never written still holds its reset rank, its own index
    assign rank_eff = r_pvld ? rank_q : r_pk;
    assign is_self  = (r_pk == r_f);

    pfr_ram #(
        .WIDTH (TW),
        .DEPTH (FRAMES)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (tag_we),
        .i_waddr (n_f),
        .i_wdata (r_tag),
        .i_re    (issue && (r_state == S_SCAN)),
        .i_raddr (rd_addr),
        .o_rdata (tag_q)
    );

    pfr_ram #(
        .WIDTH (FW),
        .DEPTH (FRAMES)
    ) u_rank_ram (
        .i_clk   (i_clk),
        .i_we    (rank_we),
        .i_waddr (r_pk),
        .i_wdata (rank_wdata),
        .i_re    (issue),
        .i_raddr (rd_addr),
        .o_rdata (rank_q)
    );

    pfr_cmp #(
        .TW (TW),
        .FW (FW)
    ) u_cmp (
        .i_tag_a    (tag_q),
        .i_tag_b    (r_tag),
        .i_rank     (rank_eff),
        .i_ref      (r_ref),
        .o_res      (cmp),
        .o_rank_dec (rank_dec)
    );

    always_comb begin
        n_hit  = 1'b0;
        n_repl = 1'b0;
        tag_we = 1'b0;
        if (r_found) begin
            n_hit = 1'b1;
            n_f   = r_hit_idx;
            n_ref = r_hit_rank;
        end else if (r_fill < CW'(FRAMES)) begin
            n_f   = r_fill[FW-1:0];
            n_ref = r_fill_rank;
        end else if (r_policy == pfr_pkg::POL_LRU) begin
            n_repl = 1'b1;
            n_f    = r_lru_idx;
            n_ref  = '0;
        end else begin
            n_repl = 1'b1;
            n_f    = r_fifo;
            n_ref  = '0;
        end
        if (r_state == S_DECIDE) begin
            tag_we = !r_found;
        end
    end

    // aging pass: the touched frame goes to the top, ranks above it drop by one
    assign rank_we    = (r_state == S_UPD) && r_pv && (is_self || cmp.rank_above);
    assign rank_wdata = is_self ? FW'(FRAMES - 1) : rank_dec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_policy   <= pfr_pkg::POL_FIFO;
            r_cnt      <= '0;
            r_pv       <= 1'b0;
            r_found    <= 1'b0;
            r_fill     <= '0;
            r_fifo     <= '0;
            r_rank_vld <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            if (apb_wr && (paddr == pfr_pkg::APB_AW'(pfr_pkg::REG_POLICY * 4))) begin
                r_policy <= pwdata[0];
            end

            r_pv   <= issue;
            r_pk   <= rd_addr;
            r_pvld <= r_rank_vld[rd_addr];
            if (issue) begin
                r_cnt <= r_cnt + CW'(1);
            end

            if (rank_we) begin
                r_rank_vld[r_pk] <= 1'b1;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_tag   <= {i_process_id, i_virtual_address[pfr_pkg::ADDR_W-1:PAGE_BITS]};
                        r_cnt   <= '0;
                        r_found <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_pv) begin
                        if (cmp.tag_eq && ({1'b0, r_pk} < r_fill) && !r_found) begin
                            r_found    <= 1'b1;
                            r_hit_idx  <= r_pk;
                            r_hit_rank <= rank_eff;
                        end
                        if (cmp.rank_zero) begin
                            r_lru_idx <= r_pk;
                        end
                        if ({1'b0, r_pk} == r_fill) begin
                            r_fill_rank <= rank_eff;
                        end
                        if (r_pk == FW'(FRAMES - 1)) begin
                            r_state <= S_DECIDE;
                        end
                    end
                end
                S_DECIDE: begin
                    r_f       <= n_f;
                    r_ref     <= n_ref;
                    r_o_hit   <= n_hit;
                    r_o_frame <= n_f;
                    r_o_repl  <= n_repl;
                    if (!r_found && (r_fill < CW'(FRAMES))) begin
                        r_fill <= r_fill + CW'(1);
                    end
                    if (n_repl && (r_policy == pfr_pkg::POL_FIFO)) begin
                        r_fifo <= (r_fifo == FW'(FRAMES - 1)) ? '0 : r_fifo + FW'(1);
                    end
                    if (r_policy == pfr_pkg::POL_LRU) begin
                        r_cnt   <= '0;
                        r_state <= S_UPD;
                    end else begin
                        r_o_valid <= 1'b1;
                        r_state   <= S_RESP;
                    end
                end
                S_UPD: begin
                    if (r_pv && (r_pk == FW'(FRAMES - 1))) begin
                        r_o_valid <= 1'b1;
                        r_state   <= S_RESP;
                    end
                end
                S_RESP: begin
                    if (i_ready) begin
                        r_o_valid <= 1'b0;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = r_o_valid;
    assign o_hit         = r_o_hit;
    assign o_frame_index = r_o_frame;
    assign o_replaced    = r_o_repl;

endmodule

@@ rtl/pfr_ram.sv @@
// ----------------------------------------------------------------------------
// pfr_ram
// generic single-clock ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module pfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/pfr_cmp.sv @@
// ----------------------------------------------------------------------------
// pfr_cmp
// shared compare unit: tag match, rank test and rank decrement for one frame
// ----------------------------------------------------------------------------
module pfr_cmp #(
    parameter int TW = 23,
    parameter int FW = 6
) (
    input  logic              [TW-1:0] i_tag_a,
    input  logic              [TW-1:0] i_tag_b,
    input  logic              [FW-1:0] i_rank,
    input  logic              [FW-1:0] i_ref,
    output pfr_pkg::t_cmp_res          o_res,
    output logic              [FW-1:0] o_rank_dec
);

    always_comb begin
        o_res.tag_eq     = (i_tag_a == i_tag_b);
        o_res.rank_zero  = (i_rank == '0);
        o_res.rank_above = (i_rank > i_ref);
        o_rank_dec       = i_rank - FW'(1);
    end

endmodule

@@ rtl/pfr_checker.sv @@
// ----------------------------------------------------------------------------
// pfr_checker
// port-level checks of the page frame replacer, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pfr_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic pready,
    input logic i_valid,
    input logic o_ready,
    input logic o_valid,
    input logic i_ready,
    input logic o_hit,
    input logic o_replaced
);

    // one access in flight: never ready while a result beat waits
    `ASSERT_CLK(a_one_in_flight, i_clk, i_rst_n, !(o_ready && o_valid), "ready while result pending")

    // an accepted beat closes the input side for the next cycle
    `ASSERT_CLK(a_busy_after_accept, i_clk, i_rst_n, (i_valid && o_ready) |=> !o_ready, "ready right after accept")

    // a stalled result beat stays valid and holds its hit and replaced flags
    `ASSERT_CLK(a_result_holds, i_clk, i_rst_n, (o_valid && !i_ready) |=> (o_valid && $stable(o_hit) && $stable(o_replaced)), "result changed under stall")

    // a resident page never evicts anything
    `ASSERT_CLK(a_hit_no_evict, i_clk, i_rst_n, o_valid |-> !(o_hit && o_replaced), "hit with eviction")

    `ASSERT_ALWAYS(a_pready_high, i_clk, pready, "pready low")

endmodule

bind page_frame_fifo_lru_replacer pfr_checker u_pfr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .pready     (pready),
    .i_valid    (i_valid),
    .o_ready    (o_ready),
    .o_valid    (o_valid),
    .i_ready    (i_ready),
    .o_hit      (o_hit),
    .o_replaced (o_replaced)
);

@@ tb/tb_page_frame_fifo_lru_replacer.sv @@
// ----------------------------------------------------------------------------
// tb_page_frame_fifo_lru_replacer
// self-checking bench for the fifo/lru page frame table
// ----------------------------------------------------------------------------
// a driver feeds access beats from a queue that the main initial block fills
// phase by phase. an in-bench copy of the frame table predicts hit, frame and
// eviction for each accepted access, and a monitor checks every result beat
// against the oldest prediction. the policy register is rewritten over apb
// between phases once the table is quiet. both channels idle in random bursts.
// ----------------------------------------------------------------------------
module tb_page_frame_fifo_lru_replacer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAMES    = pfr_pkg::FRAMES_DEF;
    localparam int PAGE_BITS = pfr_pkg::PAGE_BITS_DEF;
    localparam int ADDR_W    = pfr_pkg::ADDR_W;
    localparam int PID_W     = pfr_pkg::PID_W;
    localparam int APB_AW    = pfr_pkg::APB_AW;
    localparam int APB_DW    = pfr_pkg::APB_DW;
    localparam int FW        = $clog2(FRAMES);
    localparam int VPN_W     = ADDR_W - PAGE_BITS;
    localparam int HOLD_LEN  = 300;
    localparam logic [APB_AW-1:0] POLICY_ADDR = APB_AW'(pfr_pkg::REG_POLICY * 4);

    typedef struct packed {
        logic [PID_W-1:0]  pid;
        logic [ADDR_W-1:0] va;
    } t_access;

    typedef struct packed {
        logic          hit;
        logic [FW-1:0] frame;
        logic          replaced;
    } t_lookup;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [APB_AW-1:0]  paddr = '0;
    logic [APB_DW-1:0]  pwdata = '0;
    logic [APB_DW-1:0]  prdata;
    logic               pready;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [PID_W-1:0]   i_process_id = '0;
    logic [ADDR_W-1:0]  i_virtual_address = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic               o_hit;
    logic [FW-1:0]      o_frame_index;
    logic               o_replaced;

    page_frame_fifo_lru_replacer u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_process_id      (i_process_id),
        .i_virtual_address (i_virtual_address),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_hit             (o_hit),
        .o_frame_index     (o_frame_index),
        .o_replaced        (o_replaced)
    );

    // shadow frame table
    logic             cur_policy = pfr_pkg::POL_FIFO;
    logic             fr_used  [FRAMES];
    logic [PID_W-1:0] fr_owner [FRAMES];
    logic [VPN_W-1:0] fr_page  [FRAMES];
    logic [FW-1:0]    fr_rank  [FRAMES];
    logic [FW-1:0]    fifo_ptr;
    int               fill_cnt;

    t_access access_q[$];
    t_lookup lookup_q[$];

    // working set used to build well-formed access streams
    logic [PID_W-1:0] ws_pid [128];
    logic [VPN_W-1:0] ws_vpn [128];

    int errors     = 0;
    int idle_odds  = 0;
    int gap_left   = 0;
    int stall_left = 0;
    int hold_left  = 0;
    int hold_asked = 0;
    int hold_taken = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #15_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic void reset_table();
        int k;
        for (k = 0; k < FRAMES; k++) begin
            fr_used[k]  = 1'b0;
            fr_owner[k] = '0;
            fr_page[k]  = '0;
            fr_rank[k]  = FW'(k);
        end
        fifo_ptr = '0;
        fill_cnt = 0;
    endfunction

    // frame becomes most recent, everything above it moves down one rank
    function automatic void promote_frame(int f);
        logic [FW-1:0] r;
        int k;
        r = fr_rank[f];
        for (k = 0; k < FRAMES; k++) begin
            if (fr_rank[k] > r) fr_rank[k] = fr_rank[k] - 1'b1;
        end
        fr_rank[f] = FW'(FRAMES - 1);
    endfunction

    function automatic t_lookup translate_access(logic [PID_W-1:0] pid, logic [ADDR_W-1:0] va);
        t_lookup res;
        logic [VPN_W-1:0] vpn;
        int f;
        vpn = VPN_W'(va >> PAGE_BITS);
        res = '0;
        for (f = 0; f < FRAMES; f++) begin
            if (fr_used[f] && fr_owner[f] == pid && fr_page[f] == vpn) begin
                if (cur_policy == pfr_pkg::POL_LRU) promote_frame(f);
                res.hit   = 1'b1;
                res.frame = FW'(f);
                return res;
            end
        end
        if (fill_cnt < FRAMES) begin
            f = fill_cnt;
            fr_used[f] = 1'b1;
            fill_cnt++;
        end else begin
            res.replaced = 1'b1;
            if (cur_policy == pfr_pkg::POL_LRU) begin
                f = 0;
                while (fr_rank[f] != '0) f++;
            end else begin
                f = int'(fifo_ptr);
                fifo_ptr = fifo_ptr + 1'b1;
            end
        end
        fr_owner[f] = pid;
        fr_page[f]  = vpn;
        if (cur_policy == pfr_pkg::POL_LRU) promote_frame(f);
        res.frame = FW'(f);
        return res;
    endfunction

    // driver: one access beat at a time, gaps drawn after each accepted beat
    always @(posedge i_clk) begin
        t_access nxt;
        logic    drive;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            drive = i_valid;
            if (i_valid && o_ready) begin
                lookup_q.push_back(translate_access(i_process_id, i_virtual_address));
                drive = 1'b0;
                if (idle_odds != 0 && $urandom_range(idle_odds - 1, 0) == 0)
                    gap_left = $urandom_range(1, 9);
            end
            if (!drive) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (access_q.size() > 0) begin
                    nxt = access_q.pop_front();
                    i_process_id      <= nxt.pid;
                    i_virtual_address <= nxt.va;
                    drive = 1'b1;
                end
            end
            i_valid <= drive;
        end
    end

    // monitor: checks result beats and throttles i_ready
    always @(posedge i_clk) begin
        t_lookup want;
        logic    rdy;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (lookup_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result beat: hit=%0b frame=%0d replaced=%0b",
                             $time, o_hit, o_frame_index, o_replaced);
                end else begin
                    want = lookup_q.pop_front();
                    if (o_hit !== want.hit) begin
                        errors++;
                        if (errors < 200)
                            $display("%0t: hit mismatch: expected %0b, actual %0b",
                                     $time, want.hit, o_hit);
                    end
                    if (o_frame_index !== want.frame) begin
                        errors++;
                        if (errors < 200)
                            $display("%0t: frame_index mismatch: expected %0d, actual %0d",
                                     $time, want.frame, o_frame_index);
                    end
                    if (o_replaced !== want.replaced) begin
                        errors++;
                        if (errors < 200)
                            $display("%0t: replaced mismatch: expected %0b, actual %0b",
                                     $time, want.replaced, o_replaced);
                    end
                end
            end
            if (hold_taken != hold_asked) begin
                hold_taken = hold_asked;
                hold_left  = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
                if (idle_odds != 0 && $urandom_range(idle_odds - 1, 0) == 0)
                    stall_left = $urandom_range(1, 9);
            end
            i_ready <= rdy;
        end
    end

    task automatic queue_access(logic [PID_W-1:0] pid, logic [ADDR_W-1:0] va);
        t_access a;
        a.pid = pid;
        a.va  = va;
        access_q.push_back(a);
    endtask

    task automatic build_working_set(int n);
        int k;
        for (k = 0; k < n; k++) begin
            ws_pid[k] = PID_W'($urandom_range(0, 7));
            ws_vpn[k] = VPN_W'($urandom);
        end
    endtask

    // mostly working-set accesses with a hot quarter, the rest fully random
    task automatic queue_mixed(int count, int set_size, int noise_pct);
        int k;
        int idx;
        for (k = 0; k < count; k++) begin
            if ($urandom_range(0, 99) < noise_pct) begin
                queue_access(PID_W'($urandom), $urandom);
            end else begin
                if ($urandom_range(0, 1) == 0) idx = $urandom_range(0, set_size / 4);
                else idx = $urandom_range(0, set_size - 1);
                queue_access(ws_pid[idx], {ws_vpn[idx], PAGE_BITS'($urandom)});
            end
        end
    endtask

    // round-robin over 64 pages: under lru every hit of the second pass lands
    // on the least recent frame
    task automatic queue_sweep(int passes);
        int p;
        int k;
        for (p = 0; p < passes; p++) begin
            for (k = 0; k < FRAMES; k++)
                queue_access(ws_pid[k], {ws_vpn[k], PAGE_BITS'($urandom)});
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (access_q.size() != 0 || i_valid || lookup_q.size() != 0 || !o_ready)
            @(negedge i_clk);
    endtask

    task automatic set_policy(logic pol);
        logic [APB_DW-1:0] data;
        data    = $urandom;
        data[0] = pol;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= POLICY_ADDR;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_policy = pol;
    endtask

    initial begin
        reset_table();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: page boundaries, pid extremes, same page under other pid
        idle_odds = 4;
        queue_access(3'd0, 32'h0000_0000);
        queue_access(3'd7, 32'hFFFF_FFFF);
        queue_access(3'd0, 32'h0000_0FFF);
        queue_access(3'd7, 32'hFFFF_F000);
        queue_access(3'd7, 32'h0000_0000);
        queue_access(3'd0, 32'hFFFF_FFFF);
        queue_access(3'd5, 32'h0000_1000);
        queue_access(3'd2, 32'hAAAA_AAAA);
        queue_access(3'd5, 32'h5555_5555);
        queue_access(3'd0, 32'h0000_0ABC);
        wait_drained();

        set_policy(pfr_pkg::POL_LRU);
        build_working_set(48);
        queue_mixed(150, 48, 10);
        wait_drained();

        idle_odds = 0;
        build_working_set(FRAMES);
        queue_sweep(2);
        wait_drained();

        // fifo with a long receiver hold while accesses keep coming
        set_policy(pfr_pkg::POL_FIFO);
        idle_odds = 3;
        build_working_set(100);
        queue_mixed(350, 100, 15);
        repeat (20) @(negedge i_clk);
        hold_asked++;
        wait_drained();

        set_policy(pfr_pkg::POL_LRU);
        idle_odds = 2;
        build_working_set(80);
        queue_mixed(300, 80, 15);
        wait_drained();

        set_policy(pfr_pkg::POL_FIFO);
        idle_odds = 5;
        build_working_set(70);
        queue_mixed(250, 70, 10);
        wait_drained();

        // closing stretch without idling
        set_policy(pfr_pkg::POL_LRU);
        idle_odds = 0;
        build_working_set(72);
        queue_mixed(300, 72, 10);
        wait_drained();

        repeat (2 * FRAMES + 8) @(posedge i_clk);
        if (errors == 0 && lookup_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
